// ===== rtl/drb_pkg.sv =====
// Package for the DRAM bank row buffer block: command codes, back-end op codes,
// the queued command word and the back-end state type. No dependencies.
package drb_pkg;

  typedef enum logic [2:0] {
    FUNC_ACTIVATE  = 3'd0,
    FUNC_READ      = 3'd1,
    FUNC_READ_P    = 3'd2,
    FUNC_WRITE     = 3'd3,
    FUNC_WRITE_P   = 3'd4,
    FUNC_PRECHARGE = 3'd5,
    FUNC_REFRESH   = 3'd6,
    FUNC_NONE      = 3'd7
  } drb_func_e;

  typedef enum logic [2:0] {
    OP_ACT,
    OP_READ,
    OP_WRITE,
    OP_PRE,
    OP_REF
  } drb_op_e;

  typedef struct packed {
    drb_op_e    op;
    logic       row_ok;
    logic       col_ok;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] data;
  } drb_cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_EXEC,
    ST_LOAD
  } drb_state_e;

endpackage

// ===== rtl/drb_front.sv =====
// Front end of the DRAM bank row buffer: input handshake, command decode and
// address range checks. Depends on drb_pkg.
module drb_front import drb_pkg::*; #(
  parameter int ROW_COUNT = 256,
  parameter int COL_COUNT = 256
) (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] func_i,
  input  logic [7:0] row_addr_i,
  input  logic [7:0] col_addr_i,
  input  logic [7:0] write_byte_i,
  input  logic       init_done_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output drb_cmd_t   q_cmd_o
);

  logic row_ok;
  logic col_ok;
  logic keep;

  assign row_ok = ({24'd0, row_addr_i} < 32'(ROW_COUNT));
  assign col_ok = ({24'd0, col_addr_i} < 32'(COL_COUNT));

  // Drop commands that cannot change state or give a result.
  always_comb begin
    q_cmd_o.op     = OP_PRE;
    q_cmd_o.row_ok = row_ok;
    q_cmd_o.col_ok = col_ok;
    q_cmd_o.row    = row_addr_i;
    q_cmd_o.col    = col_addr_i;
    q_cmd_o.data   = write_byte_i;
    keep           = 1'b0;
    case (drb_func_e'(func_i))
      FUNC_ACTIVATE: begin
        q_cmd_o.op = OP_ACT;
        keep       = row_ok;
      end
      FUNC_READ, FUNC_READ_P: begin
        q_cmd_o.op = OP_READ;
        keep       = 1'b1;
      end
      FUNC_WRITE, FUNC_WRITE_P: begin
        q_cmd_o.op = OP_WRITE;
        keep       = row_ok | col_ok;
      end
      FUNC_PRECHARGE: begin
        q_cmd_o.op = OP_PRE;
        keep       = 1'b1;
      end
      FUNC_REFRESH: begin
        q_cmd_o.op = OP_REF;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready_o = init_done_i & ~q_full_i;
  assign q_push_o   = in_valid_i & in_ready_o & keep;

endmodule

// ===== rtl/drb_queue.sv =====
// Two-entry command queue between the front and back ends of the DRAM bank
// row buffer. Depends on drb_pkg.
module drb_queue import drb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  drb_cmd_t push_cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output drb_cmd_t head_o
);

  drb_cmd_t   ent_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== rtl/drb_back.sv =====
// Back end of the DRAM bank row buffer: row-wide cell memory, row buffer,
// clearing pass and result register. Depends on drb_pkg.
module drb_back import drb_pkg::*; #(
  parameter int ROW_COUNT = 256,
  parameter int COL_COUNT = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  drb_cmd_t   q_head_i,
  output logic       q_pop_o,
  output logic       init_done_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_byte_o
);

  localparam int RIW = $clog2(ROW_COUNT);
  localparam int CIW = (COL_COUNT > 1) ? $clog2(COL_COUNT) : 1;

  typedef logic [COL_COUNT-1:0][7:0] row_t;

  row_t       mem_q [ROW_COUNT];
  row_t       rd_data_q;
  row_t       buf_q, buf_d;
  row_t       buf_wr;
  row_t       mem_wdata;
  logic       mem_we;
  logic       mem_re;
  logic [RIW-1:0] mem_waddr;
  logic [RIW-1:0] mem_raddr;
  logic [RIW-1:0] clr_cnt_q, clr_cnt_d;
  logic [RIW-1:0] row_idx;
  logic [CIW-1:0] col_idx;
  drb_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_free;

  assign row_idx  = RIW'(q_head_i.row);
  assign col_idx  = CIW'(q_head_i.col);
  assign out_free = ~out_valid_q | out_ready_i;

  // Buffer with the write byte merged in.
  always_comb begin
    buf_wr = buf_q;
    if (q_head_i.col_ok) begin
      buf_wr[col_idx] = q_head_i.data;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == RIW'(ROW_COUNT - 1)) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (q_valid_i && (q_head_i.op == OP_ACT || q_head_i.op == OP_REF)) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = ST_EXEC;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = row_idx;
    mem_wdata   = buf_wr;
    mem_re      = 1'b0;
    mem_raddr   = row_idx;
    buf_d       = buf_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_byte_d  = out_byte_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + RIW'(1);
      end
      ST_EXEC: begin
        if (q_valid_i) begin
          case (q_head_i.op)
            OP_ACT: begin
              q_pop_o = 1'b1;
              mem_re  = 1'b1;
            end
            OP_REF: begin
              q_pop_o   = 1'b1;
              mem_re    = 1'b1;
              mem_raddr = RIW'(ROW_COUNT - 1);
            end
            OP_READ: begin
              if (out_free) begin
                q_pop_o     = 1'b1;
                out_valid_d = 1'b1;
                out_byte_d  = q_head_i.col_ok ? buf_q[col_idx] : 8'd0;
              end
            end
            OP_WRITE: begin
              q_pop_o = 1'b1;
              buf_d   = buf_wr;
              mem_we  = q_head_i.row_ok;
            end
            OP_PRE: begin
              q_pop_o = 1'b1;
              buf_d   = '0;
            end
            default: begin
              q_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_LOAD: begin
        buf_d = rd_data_q;
      end
      default: begin
        buf_d = buf_q;
      end
    endcase
  end

  assign init_done_o = (state_q != ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign read_byte_o = out_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      buf_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      buf_q       <= buf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

endmodule

// ===== rtl/dram_bank_row_buffer_model.sv =====
// DRAM bank row buffer model: one bank of ROW_COUNT x COL_COUNT bytes held in
// a row-wide memory, plus a one-row buffer in flip-flops. Commands arrive on a
// valid/ready channel; read and read_p each return one read_byte word on the
// output channel, all other commands return nothing. After reset the block
// runs a clearing pass that zeroes every row, one row per cycle, and holds
// in_ready_o low until it ends. A front end decodes each command and drops
// the ones that cannot change state (code none, activate of an out-of-range
// row, a write with both addresses out of range); a two-entry queue then
// decouples it from the back end, which executes in order. Activate and
// refresh read the cell memory through its single registered read port and
// load the buffer in the following cycle. A write merges its byte into the
// buffer when its column is in range and, when its row is in range, writes
// the whole buffer back to that row in the same cycle. A read stalls only
// while the result register is full and not being drained; new commands can
// still enter the queue while a result waits, until the queue is full.
// Depends on drb_pkg, drb_front, drb_queue and drb_back.
module dram_bank_row_buffer_model import drb_pkg::*; #(
  parameter int ROW_COUNT = 256,
  parameter int COL_COUNT = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] func_i,
  input  logic [7:0] row_addr_i,
  input  logic [7:0] col_addr_i,
  input  logic [7:0] write_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_byte_o
);

  logic     init_done;
  logic     q_full;
  logic     q_push;
  logic     q_pop;
  logic     q_valid;
  drb_cmd_t q_push_cmd;
  drb_cmd_t q_head;

  // Decode and range-check commands; hold off input during the clearing pass.
  drb_front #(
    .ROW_COUNT(ROW_COUNT),
    .COL_COUNT(COL_COUNT)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .row_addr_i  (row_addr_i),
    .col_addr_i  (col_addr_i),
    .write_byte_i(write_byte_i),
    .init_done_i (init_done),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_push_cmd)
  );

  // Buffer decoded commands so front and back stall independently.
  drb_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_cmd_i(q_push_cmd),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .head_o    (q_head)
  );

  // Execute commands against the cell memory and row buffer.
  drb_back #(
    .ROW_COUNT(ROW_COUNT),
    .COL_COUNT(COL_COUNT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .init_done_o(init_done),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .read_byte_o(read_byte_o)
  );

endmodule
